// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the parser top, which checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ----- sv/at_rlp_pkg.sv -----
// ----------------------------------------------------------------------------
// at_rlp_pkg
// Types, constants and match tables for the reply line parser.
// ----------------------------------------------------------------------------
package at_rlp_pkg;

    localparam int LINE_BUFFER_BYTES_DEF = 64;
    localparam int FIFO_DEPTH_DEF        = 128;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int IP_TEXT_LEN = 11;

    localparam logic [7:0] CHAR_PROMPT = 8'h3E;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_W_UP   = 8'h57;
    localparam logic [7:0] CHAR_O_UP   = 8'h4F;
    localparam logic [7:0] CHAR_K_UP   = 8'h4B;
    localparam logic [7:0] CHAR_A_UP   = 8'h41;
    localparam logic [7:0] CHAR_Z_UP   = 8'h5A;
    localparam logic [7:0] CHAR_L_LO   = 8'h6C;
    localparam logic [7:0] CHAR_E_LO   = 8'h65;
    localparam logic [7:0] CHAR_D_LO   = 8'h64;
    localparam logic [7:0] CHAR_ONE    = 8'h31;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [1:0] LED_CMD_NONE = 2'd0;
    localparam logic [1:0] LED_CMD_ON   = 2'd1;
    localparam logic [1:0] LED_CMD_OFF  = 2'd2;

    // Decoded transaction handed from the front to the back.
    typedef struct packed {
        logic       drain;
        logic       is_prompt;
        logic       is_eol;
        logic       is_nul;
        logic [7:0] data;
    } op_t;

    // Result fields other than the forwarded byte.
    typedef struct packed {
        logic       line_done;
        logic       line_got_ip;
        logic       line_ok;
        logic       prompt_seen;
        logic       in_transparent;
        logic [1:0] led_command;
        logic       overrun_flag;
        logic       fwd_valid;
    } res_t;

    // "WIFI GOT IP", one character per match step.
    function automatic logic [7:0] ip_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h57;
            4'd1:    c = 8'h49;
            4'd2:    c = 8'h46;
            4'd3:    c = 8'h49;
            4'd4:    c = 8'h20;
            4'd5:    c = 8'h47;
            4'd6:    c = 8'h4F;
            4'd7:    c = 8'h54;
            4'd8:    c = 8'h20;
            4'd9:    c = 8'h49;
            4'd10:   c = 8'h50;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/at_rlp_front.sv -----
// ----------------------------------------------------------------------------
// at_rlp_front
// Accepts input transactions, classifies each byte and queues it for the back.
// ----------------------------------------------------------------------------
module at_rlp_front import at_rlp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_rx_byte,
    output logic       op_valid,
    input  logic       op_ready,
    output op_t        op
);

    op_t               q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    op_t               op_in;
    logic              push;
    logic              pop;

    always_comb begin
        op_in.drain     = s_action;
        op_in.is_prompt = (s_rx_byte == CHAR_PROMPT);
        op_in.is_eol    = (s_rx_byte == CHAR_CR) || (s_rx_byte == CHAR_LF);
        op_in.is_nul    = (s_rx_byte == CHAR_NUL);
        op_in.data      = s_rx_byte;
    end

    assign s_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign op_valid = (count_reg != '0);
    assign op       = q_reg[rd_ptr_reg];
    assign push     = s_valid && s_ready;
    assign pop      = op_valid && op_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- sv/at_rlp_back.sv -----
// ----------------------------------------------------------------------------
// at_rlp_back
// Executes queued transactions: line matchers, mode, led matcher, forward
// FIFO, and the result register.
// ----------------------------------------------------------------------------
module at_rlp_back import at_rlp_pkg::*; #(
    parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF,
    parameter int FIFO_DEPTH        = FIFO_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       op_valid,
    output logic       op_ready,
    input  op_t        op,
    output logic       res_valid,
    input  logic       res_ready,
    output res_t       res,
    output logic [7:0] res_fwd_byte
);

    localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
    localparam int PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [1:0] LED_S_IDLE = 2'd0;
    localparam logic [1:0] LED_S_L    = 2'd1;
    localparam logic [1:0] LED_S_LE   = 2'd2;
    localparam logic [1:0] LED_S_LED  = 2'd3;

    logic             mode_reg,    mode_next;
    logic [LEN_W-1:0] len_reg,     len_next;
    logic [3:0]       ip_prog_reg, ip_prog_next;
    logic             ip_found_reg, ip_found_next;
    logic             ok_prog_reg, ok_prog_next;
    logic             ok_found_reg, ok_found_next;
    logic             nul_reg,     nul_next;
    logic [1:0]       led_reg,     led_next;
    logic [PTR_W-1:0] head_reg,    head_next;
    logic [PTR_W-1:0] tail_reg,    tail_next;
    logic             ovr_reg,     ovr_next;
    logic             res_valid_reg;
    res_t             res_reg,     res_next;
    logic [7:0]       rd_data_reg;
    logic [7:0]       mem [FIFO_DEPTH];

    logic             adv;
    logic             fire;
    logic             we;
    logic             re;
    logic [LEN_W:0]   len_inc;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;
    logic [7:0]       folded;

    assign adv      = !res_valid_reg || res_ready;
    assign op_ready = adv;
    assign fire     = op_valid && adv;
    assign len_inc  = {1'b0, len_reg} + 1'b1;
    assign head_inc = (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign folded   = ((op.data >= CHAR_A_UP) && (op.data <= CHAR_Z_UP)) ?
                      op.data + CASE_OFFSET : op.data;

    always_comb begin
        mode_next     = mode_reg;
        len_next      = len_reg;
        ip_prog_next  = ip_prog_reg;
        ip_found_next = ip_found_reg;
        ok_prog_next  = ok_prog_reg;
        ok_found_next = ok_found_reg;
        nul_next      = nul_reg;
        led_next      = led_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        ovr_next      = ovr_reg;
        we            = 1'b0;
        re            = 1'b0;
        res_next      = '0;

        if (op.drain) begin
            if (tail_reg != head_reg) begin
                re                 = 1'b1;
                tail_next          = tail_inc;
                res_next.fwd_valid = 1'b1;
            end
        end else if (mode_reg) begin
            case (led_reg)
                LED_S_IDLE: led_next = (folded == CHAR_L_LO) ? LED_S_L : LED_S_IDLE;
                LED_S_L: begin
                    led_next = (folded == CHAR_E_LO) ? LED_S_LE :
                               ((folded == CHAR_L_LO) ? LED_S_L : LED_S_IDLE);
                end
                LED_S_LE: begin
                    led_next = (folded == CHAR_D_LO) ? LED_S_LED :
                               ((folded == CHAR_L_LO) ? LED_S_L : LED_S_IDLE);
                end
                default: begin
                    if (folded == CHAR_ONE) begin
                        res_next.led_command = LED_CMD_ON;
                    end else if (folded == CHAR_ZERO) begin
                        res_next.led_command = LED_CMD_OFF;
                    end
                    led_next = (folded == CHAR_L_LO) ? LED_S_L : LED_S_IDLE;
                end
            endcase
            if (head_inc != tail_reg) begin
                we        = 1'b1;
                head_next = head_inc;
            end else begin
                ovr_next  = 1'b1;
            end
        end else if (op.is_prompt || op.is_eol ||
                     (len_inc >= (LEN_W + 1)'(LINE_BUFFER_BYTES - 1))) begin
            if (op.is_prompt) begin
                mode_next            = 1'b1;
                res_next.prompt_seen = 1'b1;
            end else if (op.is_eol && (len_reg != '0)) begin
                res_next.line_done   = 1'b1;
                res_next.line_got_ip = ip_found_reg;
                res_next.line_ok     = ok_found_reg;
            end
            len_next      = '0;
            ip_prog_next  = '0;
            ip_found_next = 1'b0;
            ok_prog_next  = 1'b0;
            ok_found_next = 1'b0;
            nul_next      = 1'b0;
        end else begin
            len_next = len_inc[LEN_W-1:0];
            if (!nul_reg) begin
                if (op.is_nul) begin
                    nul_next = 1'b1;
                end else begin
                    if (!ip_found_reg) begin
                        if ((ip_prog_reg < 4'(IP_TEXT_LEN)) &&
                            (op.data == ip_char(ip_prog_reg))) begin
                            ip_prog_next = ip_prog_reg + 1'b1;
                        end else begin
                            ip_prog_next = (op.data == CHAR_W_UP) ? 4'd1 : 4'd0;
                        end
                        ip_found_next = (ip_prog_next >= 4'(IP_TEXT_LEN));
                    end
                    if (!ok_found_reg) begin
                        if (ok_prog_reg && (op.data == CHAR_K_UP)) begin
                            ok_found_next = 1'b1;
                        end else begin
                            ok_prog_next  = (op.data == CHAR_O_UP);
                        end
                    end
                end
            end
        end

        res_next.in_transparent = mode_next;
        res_next.overrun_flag   = ovr_next;
    end

    always_ff @(posedge aclk) begin
        if (fire && we) begin
            mem[head_reg] <= op.data;
        end
        if (fire && re) begin
            rd_data_reg <= mem[tail_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            len_reg       <= '0;
            ip_prog_reg   <= '0;
            ip_found_reg  <= 1'b0;
            ok_prog_reg   <= 1'b0;
            ok_found_reg  <= 1'b0;
            nul_reg       <= 1'b0;
            led_reg       <= LED_S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            ovr_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                res_valid_reg <= op_valid;
            end
            if (fire) begin
                mode_reg     <= mode_next;
                len_reg      <= len_next;
                ip_prog_reg  <= ip_prog_next;
                ip_found_reg <= ip_found_next;
                ok_prog_reg  <= ok_prog_next;
                ok_found_reg <= ok_found_next;
                nul_reg      <= nul_next;
                led_reg      <= led_next;
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                ovr_reg      <= ovr_next;
            end
        end
    end

    assign res_valid    = res_valid_reg;
    assign res          = res_reg;
    assign res_fwd_byte = res_reg.fwd_valid ? rd_data_reg : 8'h00;

endmodule

// ----- sv/at_reply_line_parser_top.sv -----
// ----------------------------------------------------------------------------
// at_reply_line_parser_top
// Modem reply line parser with transparent-mode forward FIFO.
// ----------------------------------------------------------------------------
// Every accepted transaction returns exactly one result. The block takes one
// transaction per clock cycle while s_ready is high; a result passes through
// the queue and then the back's result register before it is offered on the
// m_ channel. A two-entry queue decouples the classifying front from the
// executing back, and the back's result register takes a new result as the
// waiting one is taken; the rate is set by the back, which completes one
// transaction per cycle unless a result waits untaken, reading or writing the
// forward FIFO memory, never both for one transaction. When m_ready stays low
// the queue fills and s_ready drops after two more transactions. The forward
// FIFO holds FIFO_DEPTH - 1 bytes and needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module at_reply_line_parser_top import at_rlp_pkg::*; #(
    parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF,
    parameter int FIFO_DEPTH        = FIFO_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_line_done,
    output logic       m_line_got_ip,
    output logic       m_line_ok,
    output logic       m_prompt_seen,
    output logic       m_in_transparent,
    output logic [1:0] m_led_command,
    output logic       m_overrun_flag,
    output logic       m_fwd_valid,
    output logic [7:0] m_fwd_byte
);

    logic op_valid;
    logic op_ready;
    op_t  op;
    res_t res;

    at_rlp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_rx_byte (s_rx_byte),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op)
    );

    at_rlp_back #(
        .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES),
        .FIFO_DEPTH        (FIFO_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op           (op),
        .res_valid    (m_valid),
        .res_ready    (m_ready),
        .res          (res),
        .res_fwd_byte (m_fwd_byte)
    );

    assign m_line_done      = res.line_done;
    assign m_line_got_ip    = res.line_got_ip;
    assign m_line_ok        = res.line_ok;
    assign m_prompt_seen    = res.prompt_seen;
    assign m_in_transparent = res.in_transparent;
    assign m_led_command    = res.led_command;
    assign m_overrun_flag   = res.overrun_flag;
    assign m_fwd_valid      = res.fwd_valid;

    `ASSERT_NEXT(a_mode_sticky, aclk, aresetn, m_valid && m_ready && m_in_transparent, !m_valid || m_in_transparent)
    `ASSERT_NEXT(a_overrun_sticky, aclk, aresetn, m_valid && m_ready && m_overrun_flag, !m_valid || m_overrun_flag)
    `ASSERT_IMPLIES(a_line_flags, aclk, aresetn, m_valid && (m_line_got_ip || m_line_ok), m_line_done && !m_in_transparent && !m_fwd_valid)
    `ASSERT_IMPLIES(a_led_mode, aclk, aresetn, m_valid && (m_led_command != LED_CMD_NONE), m_in_transparent && !m_prompt_seen)

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the modem reply line parser. Plain tasks drive byte and drain
// transactions under valid/ready, with random idling on both channels. A
// scoreboard class predicts every result from its own model of the line
// matchers, the transparent-mode led matcher and the forward FIFO, then checks
// each result transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_top import at_rlp_pkg::*;;

    localparam int WATCHDOG_CYCLES  = 2000;
    localparam int IDLE_PHASE_ITEMS = 650;
    localparam int COMMAND_ITEMS    = 800;
    localparam int TOTAL_ITEMS      = 1900;
    localparam int SETTLE_CYCLES    = 8;

    typedef struct packed {
        logic       line_done;
        logic       line_got_ip;
        logic       line_ok;
        logic       prompt_seen;
        logic       in_transparent;
        logic [1:0] led_command;
        logic       overrun_flag;
        logic       fwd_valid;
        logic [7:0] fwd_byte;
    } parser_reply_t;

    class reply_scoreboard;
        bit            transparent;
        int            line_len;
        int            ip_pos;
        bit            ip_found;
        int            ok_pos;
        bit            ok_found;
        bit            zero_seen;
        int            led_pos;
        logic [7:0]    fwd_mem [FIFO_DEPTH_DEF];
        int            fwd_head;
        int            fwd_tail;
        bit            overrun;
        int            mismatches;
        string         ip_phrase;
        parser_reply_t pending_replies [$];

        function new();
            ip_phrase   = "WIFI GOT IP";
            transparent = 1'b0;
            restart_line();
            led_pos     = 0;
            fwd_head    = 0;
            fwd_tail    = 0;
            overrun     = 1'b0;
            mismatches  = 0;
        endfunction

        function void restart_line();
            line_len  = 0;
            ip_pos    = 0;
            ip_found  = 1'b0;
            ok_pos    = 0;
            ok_found  = 1'b0;
            zero_seen = 1'b0;
        endfunction

        function void match_line_byte(logic [7:0] b);
            if (zero_seen)
                return;
            if (b == CHAR_NUL) begin
                zero_seen = 1'b1;
                return;
            end
            if (!ip_found) begin
                if (ip_pos < IP_TEXT_LEN && b == 8'(ip_phrase[ip_pos]))
                    ip_pos++;
                else
                    ip_pos = (b == CHAR_W_UP) ? 1 : 0;
                if (ip_pos >= IP_TEXT_LEN)
                    ip_found = 1'b1;
            end
            if (!ok_found) begin
                if (ok_pos != 0 && b == CHAR_K_UP)
                    ok_found = 1'b1;
                else
                    ok_pos = (b == CHAR_O_UP) ? 1 : 0;
            end
        endfunction

        function logic [1:0] led_advance(logic [7:0] b);
            logic [7:0] c;
            logic [1:0] cmd;
            c   = b;
            cmd = LED_CMD_NONE;
            if (c >= CHAR_A_UP && c <= CHAR_Z_UP)
                c = c + CASE_OFFSET;
            case (led_pos)
                0: led_pos = (c == CHAR_L_LO) ? 1 : 0;
                1: led_pos = (c == CHAR_E_LO) ? 2 : ((c == CHAR_L_LO) ? 1 : 0);
                2: led_pos = (c == CHAR_D_LO) ? 3 : ((c == CHAR_L_LO) ? 1 : 0);
                default: begin
                    if (c == CHAR_ONE)
                        cmd = LED_CMD_ON;
                    else if (c == CHAR_ZERO)
                        cmd = LED_CMD_OFF;
                    led_pos = (c == CHAR_L_LO) ? 1 : 0;
                end
            endcase
            return cmd;
        endfunction

        function void note_input(logic drain, logic [7:0] b);
            parser_reply_t r;
            int            next_head;
            r = '0;
            if (drain) begin
                if (fwd_tail != fwd_head) begin
                    r.fwd_valid = 1'b1;
                    r.fwd_byte  = fwd_mem[fwd_tail];
                    fwd_tail    = (fwd_tail + 1) % FIFO_DEPTH_DEF;
                end
            end else if (transparent) begin
                r.led_command = led_advance(b);
                next_head = (fwd_head + 1) % FIFO_DEPTH_DEF;
                if (next_head != fwd_tail) begin
                    fwd_mem[fwd_head] = b;
                    fwd_head = next_head;
                end else begin
                    overrun = 1'b1;
                end
            end else if (b == CHAR_PROMPT) begin
                transparent   = 1'b1;
                r.prompt_seen = 1'b1;
                restart_line();
            end else if (b == CHAR_CR || b == CHAR_LF) begin
                if (line_len > 0) begin
                    r.line_done   = 1'b1;
                    r.line_got_ip = ip_found;
                    r.line_ok     = ok_found;
                end
                restart_line();
            end else if (line_len + 1 >= LINE_BUFFER_BYTES_DEF - 1) begin
                restart_line();
            end else begin
                match_line_byte(b);
                line_len++;
            end
            r.in_transparent = transparent;
            r.overrun_flag   = overrun;
            pending_replies.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(parser_reply_t act);
            parser_reply_t exp;
            if (pending_replies.size() == 0) begin
                $error("result transaction with no prediction waiting");
                mismatches++;
                return;
            end
            exp = pending_replies.pop_front();
            compare_field("line_done", exp.line_done, act.line_done);
            compare_field("line_got_ip", exp.line_got_ip, act.line_got_ip);
            compare_field("line_ok", exp.line_ok, act.line_ok);
            compare_field("prompt_seen", exp.prompt_seen, act.prompt_seen);
            compare_field("in_transparent", exp.in_transparent, act.in_transparent);
            compare_field("led_command", exp.led_command, act.led_command);
            compare_field("overrun_flag", exp.overrun_flag, act.overrun_flag);
            compare_field("fwd_valid", exp.fwd_valid, act.fwd_valid);
            compare_field("fwd_byte", exp.fwd_byte, act.fwd_byte);
        endfunction

        function int waiting();
            return pending_replies.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic       s_action  = 1'b0;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_line_done;
    logic       m_line_got_ip;
    logic       m_line_ok;
    logic       m_prompt_seen;
    logic       m_in_transparent;
    logic [1:0] m_led_command;
    logic       m_overrun_flag;
    logic       m_fwd_valid;
    logic [7:0] m_fwd_byte;

    reply_scoreboard replies;
    int              items_sent   = 0;
    int              src_idle_pct = 0;
    int              dst_idle_pct = 0;

    at_reply_line_parser_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_line_done      (m_line_done),
        .m_line_got_ip    (m_line_got_ip),
        .m_line_ok        (m_line_ok),
        .m_prompt_seen    (m_prompt_seen),
        .m_in_transparent (m_in_transparent),
        .m_led_command    (m_led_command),
        .m_overrun_flag   (m_overrun_flag),
        .m_fwd_valid      (m_fwd_valid),
        .m_fwd_byte       (m_fwd_byte)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            replies.check_result(parser_reply_t'({m_line_done, m_line_got_ip, m_line_ok,
                m_prompt_seen, m_in_transparent, m_led_command, m_overrun_flag,
                m_fwd_valid, m_fwd_byte}));
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[at_reply_line_parser_top] ERROR");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic drain, input logic [7:0] b);
        if (items_sent < IDLE_PHASE_ITEMS) begin
            src_idle_pct = 8;
            dst_idle_pct = 69;
        end else if (items_sent < 2 * IDLE_PHASE_ITEMS) begin
            src_idle_pct = 69;
            dst_idle_pct = 8;
        end else begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= drain;
        s_rx_byte <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        replies.note_input(drain, b);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_drain();
        send_item(1'b1, 8'($urandom_range(255)));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, 8'(s[i]));
    endtask

    function automatic logic [7:0] line_noise_byte(input bit printable);
        logic [7:0] b;
        do
            b = printable ? 8'($urandom_range(32, 126)) : 8'($urandom_range(255));
        while (b == CHAR_PROMPT);
        return b;
    endfunction

    task automatic send_reply_line();
        logic [7:0] line_bytes [$];
        string      ip_text;
        string      piece;
        int         target;
        int         pick;
        ip_text = "WIFI GOT IP";
        pick = $urandom_range(99);
        if (pick < 8)
            target = 0;
        else if (pick < 20)
            target = $urandom_range(55, 75);
        else
            target = $urandom_range(1, 20);
        while (line_bytes.size() < target) begin
            pick  = $urandom_range(99);
            piece = "";
            if (pick < 25)
                piece = ip_text;
            else if (pick < 45)
                piece = "OK";
            else if (pick < 60)
                piece = ip_text.substr(0, $urandom_range(0, IP_TEXT_LEN - 2));
            else if (pick < 65)
                piece = "O";
            else if (pick < 70)
                line_bytes.push_back(CHAR_NUL);
            else if (pick < 88)
                line_bytes.push_back(line_noise_byte(1'b1));
            else
                line_bytes.push_back(line_noise_byte(1'b0));
            for (int i = 0; i < piece.len(); i++)
                line_bytes.push_back(8'(piece[i]));
        end
        foreach (line_bytes[i]) begin
            if ($urandom_range(99) < 5)
                send_drain();
            send_item(1'b0, line_bytes[i]);
        end
        pick = $urandom_range(99);
        if (pick < 40) begin
            send_item(1'b0, CHAR_CR);
            send_item(1'b0, CHAR_LF);
        end else begin
            send_item(1'b0, (pick < 70) ? CHAR_CR : CHAR_LF);
        end
    endtask

    task automatic send_led_token();
        string      tokens [10] = '{"led1", "led0", "led1", "led0", "lled0",
                                    "leled1", "led", "ledx", "le", "ld1"};
        string      tok;
        logic [7:0] c;
        tok = tokens[$urandom_range(9)];
        for (int i = 0; i < tok.len(); i++) begin
            c = 8'(tok[i]);
            if (c >= "a" && c <= "z" && $urandom_range(1) == 1)
                c = c - CASE_OFFSET;
            send_item(1'b0, c);
        end
    endtask

    task automatic send_fill_burst();
        int n;
        n = $urandom_range(130, 150);
        repeat (n) send_item(1'b0, 8'($urandom_range(255)));
    endtask

    task automatic send_drain_burst();
        int n;
        n = $urandom_range(130, 140);
        repeat (n) send_drain();
    endtask

    task automatic send_transparent_mix(input int until_items);
        int pick;
        while (items_sent < until_items) begin
            pick = $urandom_range(999);
            if (pick < 8)
                send_fill_burst();
            else if (pick < 16)
                send_drain_burst();
            else if (pick < 420)
                send_led_token();
            else if (pick < 720)
                send_drain();
            else
                send_item(1'b0, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        replies = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_drain();
        send_item(1'b0, CHAR_CR);
        send_text("OK");
        send_item(1'b0, CHAR_LF);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, CHAR_NUL);
        send_text("OK");
        send_item(1'b0, CHAR_CR);
        send_text("WIFI GOT IPOK");
        send_item(1'b0, CHAR_LF);

        while (items_sent < COMMAND_ITEMS)
            send_reply_line();
        send_text("OK");
        send_item(1'b0, CHAR_PROMPT);

        send_transparent_mix(items_sent + 200);
        send_fill_burst();
        send_drain_burst();
        send_transparent_mix(TOTAL_ITEMS - 300);
        send_fill_burst();
        send_transparent_mix(TOTAL_ITEMS);

        s_valid <= 1'b0;
        while (replies.waiting() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (replies.mismatches == 0)
            $display("[at_reply_line_parser_top] OK");
        else
            $display("[at_reply_line_parser_top] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/at_rlp_pkg.sv
sv/at_rlp_front.sv
sv/at_rlp_back.sv
sv/at_reply_line_parser_top.sv
dv/tb_top.sv
